[rtl/lns_pkg.sv]
// Shared types and constants for the length N-statistics block.
// Used by every module of the block; depends on nothing.
package lns_pkg;

    localparam int MAX_ITEMS_DEF = 4096;
    localparam int LEN_W         = 31;
    localparam int VAL_W         = 43;
    localparam int RANK_W        = 13;
    localparam int KIND_W        = 3;
    // 49 * total needs VAL_W + 6 bits
    localparam int DIV_W         = VAL_W + 6;

    typedef enum logic [KIND_W-1:0] {
        KIND_N98,
        KIND_N75,
        KIND_N50,
        KIND_N25,
        KIND_TOTAL,
        KIND_NONE
    } t_kind;

    typedef enum logic [3:0] {
        B_IDLE,
        B_HINIT,
        B_HRD,
        B_HROOT,
        S_LEFT,
        S_RIGHT,
        S_PICK,
        W_STEP,
        E_TOP,
        E_LAST,
        B_EMIT
    } t_bstate;

endpackage

[rtl/length_nxx_statistics.sv]
// Length N-statistics top level: load side, job queue and report side.
// Depends on lns_pkg, lns_front, lns_jobq and lns_back.
//
// Lengths are taken one per cycle while a set loads; each is stored and added to
// the count and total, and lengths beyond MAX_ITEMS are dropped and flagged. After
// the item marked last, the report side heap-orders the n stored lengths and pops
// them largest first while walking running sums (the 98 percent threshold is
// compared as 50 * (sum + 1) against 49 * total, so no divider is needed), then
// emits N98, N75, N50, N25 and the total (or one none result for an empty set).
// The length store, with one read port and one write port, sets the report time;
// results then go out one per cycle while the receiver keeps up. A new set is held
// off until the walk ends; the results drain from an output register while the
// next set loads.
module length_nxx_statistics import lns_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [LEN_W-1:0]  i_length,
    input  logic              i_has_length,
    input  logic              i_last,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [KIND_W-1:0] o_stat_kind,
    output logic [VAL_W-1:0]  o_length_value,
    output logic [RANK_W-1:0] o_rank,
    output logic              o_overflow,
    output logic              o_final_res
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int JW = CW + VAL_W + 1;

    logic             release_w;
    logic             push_w, full_w, pop_w, qvalid_w;
    logic [JW-1:0]    push_job, pop_job;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [LEN_W-1:0] wr_data;

    lns_front #(.MAX_ITEMS(MAX_ITEMS), .AW(AW), .CW(CW), .JW(JW)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_length     (i_length),
        .i_has_length (i_has_length),
        .i_last       (i_last),
        .i_release    (release_w),
        .i_job_full   (full_w),
        .o_job_valid  (push_w),
        .o_job        (push_job),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    lns_jobq #(.W(JW)) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_w),
        .i_data  (push_job),
        .o_full  (full_w),
        .i_pop   (pop_w),
        .o_valid (qvalid_w),
        .o_data  (pop_job)
    );

    lns_back #(.MAX_ITEMS(MAX_ITEMS), .AW(AW), .CW(CW), .JW(JW)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (qvalid_w),
        .i_job          (pop_job),
        .o_job_pop      (pop_w),
        .o_release      (release_w),
        .i_wr_en        (wr_en),
        .i_wr_addr      (wr_addr),
        .i_wr_data      (wr_data),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_stat_kind    (o_stat_kind),
        .o_length_value (o_length_value),
        .o_rank         (o_rank),
        .o_overflow     (o_overflow),
        .o_final_res    (o_final_res)
    );

endmodule

[rtl/lns_front.sv]
// Load side: accepts lengths, writes them to the store, keeps count, sum, drop flag.
// Depends on lns_pkg; hands a finished set to the job queue.
module lns_front import lns_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF,
    parameter int AW        = $clog2(MAX_ITEMS),
    parameter int CW        = $clog2(MAX_ITEMS + 1),
    parameter int JW        = CW + VAL_W + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [LEN_W-1:0] i_length,
    input  logic             i_has_length,
    input  logic             i_last,
    input  logic             i_release,
    input  logic             i_job_full,
    output logic             o_job_valid,
    output logic [JW-1:0]    o_job,
    output logic             o_wr_en,
    output logic [AW-1:0]    o_wr_addr,
    output logic [LEN_W-1:0] o_wr_data
);

    logic [CW-1:0]    r_count, n_count;
    logic [VAL_W-1:0] r_total, n_total;
    logic             r_drop, n_drop;
    logic             r_lock;
    logic             accept;
    logic             room;

    assign o_ready = !r_lock && !i_job_full;
    assign accept  = i_valid && o_ready;
    assign room    = r_count < CW'(MAX_ITEMS);

    always_comb begin
        n_count = r_count;
        n_total = r_total;
        n_drop  = r_drop;
        if (i_has_length) begin
            if (room) begin
                n_count = r_count + 1'b1;
                n_total = r_total + VAL_W'(i_length);
            end else begin
                n_drop = 1'b1;
            end
        end
    end

    assign o_wr_en     = accept && i_has_length && room;
    assign o_wr_addr   = r_count[AW-1:0];
    assign o_wr_data   = i_length;
    assign o_job_valid = accept && i_last;
    assign o_job       = {n_count, n_total, n_drop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
            r_drop  <= 1'b0;
            r_lock  <= 1'b0;
        end else begin
            if (accept) begin
                if (i_last) begin
                    // hold off the next set until the back end frees the store
                    r_count <= '0;
                    r_total <= '0;
                    r_drop  <= 1'b0;
                    r_lock  <= 1'b1;
                end else begin
                    r_count <= n_count;
                    r_total <= n_total;
                    r_drop  <= n_drop;
                end
            end
            if (i_release) begin
                r_lock <= 1'b0;
            end
        end
    end

endmodule

[rtl/lns_jobq.sv]
// Two-entry queue of set descriptors between the load side and the report side.
// Depends on lns_pkg for VAL_W in the default width W.
module lns_jobq import lns_pkg::*; #(
    parameter int W = VAL_W + 14
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         do_push;
    logic         do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

[rtl/lns_back.sv]
// Report side: owns the length store, heap-orders it, walks running sums and
// emits the Nxx, total or none results. Depends on lns_pkg.
module lns_back import lns_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF,
    parameter int AW        = $clog2(MAX_ITEMS),
    parameter int CW        = $clog2(MAX_ITEMS + 1),
    parameter int JW        = CW + VAL_W + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  logic [JW-1:0]     i_job,
    output logic              o_job_pop,
    output logic              o_release,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [LEN_W-1:0]  i_wr_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [KIND_W-1:0] o_stat_kind,
    output logic [VAL_W-1:0]  o_length_value,
    output logic [RANK_W-1:0] o_rank,
    output logic              o_overflow,
    output logic              o_final_res
);

    localparam int SW = CW + LEN_W;
    localparam int XW = AW + 2;

    // length store
    logic [LEN_W-1:0] mem [MAX_ITEMS];
    logic [LEN_W-1:0] r_rdata;
    logic             b_we, b_re, m_we;
    logic [AW-1:0]    b_wa, b_ra, m_wa;
    logic [LEN_W-1:0] b_wd, m_wd;

    t_bstate          r_state, n_state;
    logic [CW-1:0]    r_n, n_n;
    logic [VAL_W-1:0] r_t, n_t;
    logic             r_drop, n_drop;
    logic             r_empty, n_empty;
    logic [VAL_W-1:0] r_thr [3];
    logic [DIV_W-1:0] r_t49, n_t49;
    logic [AW-1:0]    r_i, n_i;
    logic [AW-1:0]    r_root, n_root;
    logic [CW-1:0]    r_size, n_size;
    logic [LEN_W-1:0] r_val, n_val;
    logic [LEN_W-1:0] r_lval, n_lval;
    logic             r_build, n_build;
    logic [SW-1:0]    r_sum, n_sum;
    logic [CW-1:0]    r_pos, n_pos;
    logic [LEN_W-1:0] r_lastv, n_lastv;
    logic [CW-1:0]    r_rk [4];
    logic [LEN_W-1:0] r_lv [4];
    logic [2:0]       r_k, n_k;
    logic [2:0]       r_ridx, n_ridx;

    logic             r_ovalid;
    t_kind            r_okind;
    logic [VAL_W-1:0] r_oval;
    logic [RANK_W-1:0] r_orank;
    logic             r_oovf, r_ofin;

    logic             job_start;
    logic             thr_load;
    logic             rec_en;
    logic             out_load;
    logic             out_free;
    logic             sift_done;
    logic [XW-1:0]    child_l, child_r, size_x;
    logic [VAL_W+1:0] t3;
    logic [DIV_W:0]   sum1, sum50;
    logic             walk_below;
    logic [LEN_W-1:0] big_v;
    logic [AW-1:0]    big_i;
    logic             big_move;
    t_kind            ld_kind;
    logic [VAL_W-1:0] ld_val;
    logic [RANK_W-1:0] ld_rank;
    logic             ld_fin;

    assign m_we = b_we || i_wr_en;
    assign m_wa = b_we ? b_wa : i_wr_addr;
    assign m_wd = b_we ? b_wd : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            mem[m_wa] <= m_wd;
        end
        if (b_re) begin
            r_rdata <= mem[b_ra];
        end
    end

    assign child_l  = {1'b0, r_root, 1'b1};
    assign child_r  = child_l + 1'b1;
    assign size_x   = XW'(r_size);
    assign t3       = {2'b00, r_t} + {1'b0, r_t, 1'b0};
    assign sum1     = (DIV_W+1)'(r_sum) + 1'b1;
    assign sum50    = (sum1 << 5) + (sum1 << 4) + (sum1 << 1);
    assign out_free = !r_ovalid || i_ready;
    assign job_start = (r_state == B_IDLE) && i_job_valid;
    assign o_job_pop = job_start;
    assign o_release = (n_state == B_EMIT) && (r_state != B_EMIT);

    // running sum below the current threshold; for N98 the sum is below
    // floor(98 * total / 100) exactly when 50 * (sum + 1) <= 49 * total
    always_comb begin
        case (r_k[1:0])
            2'd0:    walk_below = r_sum < SW'(r_thr[0]);
            2'd1:    walk_below = r_sum < SW'(r_thr[1]);
            2'd2:    walk_below = r_sum < SW'(r_thr[2]);
            default: walk_below = sum50 <= {1'b0, r_t49};
        endcase
    end

    // larger of root value, left child and right child; the root wins a tie, and left wins a tie with right
    always_comb begin
        big_v    = r_val;
        big_i    = r_root;
        big_move = 1'b0;
        if (r_lval > big_v) begin
            big_v    = r_lval;
            big_i    = child_l[AW-1:0];
            big_move = 1'b1;
        end
        if (r_rdata > big_v) begin
            big_v    = r_rdata;
            big_i    = child_r[AW-1:0];
            big_move = 1'b1;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_t      = r_t;
        n_drop   = r_drop;
        n_empty  = r_empty;
        n_t49    = r_t49;
        n_i      = r_i;
        n_root   = r_root;
        n_size   = r_size;
        n_val    = r_val;
        n_lval   = r_lval;
        n_build  = r_build;
        n_sum    = r_sum;
        n_pos    = r_pos;
        n_lastv  = r_lastv;
        n_k      = r_k;
        n_ridx   = r_ridx;
        b_we     = 1'b0;
        b_wa     = r_root;
        b_wd     = r_val;
        b_re     = 1'b0;
        b_ra     = '0;
        thr_load = 1'b0;
        rec_en   = 1'b0;
        out_load = 1'b0;
        sift_done = 1'b0;
        ld_kind  = KIND_NONE;
        ld_val   = '0;
        ld_rank  = '0;
        ld_fin   = 1'b1;

        unique case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    n_n     = i_job[JW-1 -: CW];
                    n_t     = i_job[VAL_W:1];
                    n_drop  = i_job[0];
                    n_empty = i_job[JW-1 -: CW] == '0;
                    // 49 * total for the N98 compare
                    n_t49   = (DIV_W'(i_job[VAL_W:1]) << 5) + (DIV_W'(i_job[VAL_W:1]) << 4)
                            + DIV_W'(i_job[VAL_W:1]);
                    n_ridx  = '0;
                    n_state = (i_job[JW-1 -: CW] == '0) ? B_EMIT : B_HINIT;
                end
            end
            B_HINIT: begin
                thr_load = 1'b1;
                n_i      = AW'(r_n >> 1);
                n_size   = r_n;
                n_sum    = '0;
                n_pos    = '0;
                n_k      = '0;
                n_lastv  = '0;
                n_state  = (r_n < CW'(2)) ? W_STEP : B_HRD;
            end
            B_HRD: begin
                b_re    = 1'b1;
                b_ra    = r_i - 1'b1;
                n_state = B_HROOT;
            end
            B_HROOT: begin
                n_val   = r_rdata;
                n_root  = r_i - 1'b1;
                n_build = 1'b1;
                n_state = S_LEFT;
            end
            S_LEFT: begin
                if (child_l >= size_x) begin
                    b_we      = 1'b1;
                    sift_done = 1'b1;
                end else begin
                    b_re    = 1'b1;
                    b_ra    = child_l[AW-1:0];
                    n_state = S_RIGHT;
                end
            end
            S_RIGHT: begin
                n_lval = r_rdata;
                if (child_r < size_x) begin
                    b_re    = 1'b1;
                    b_ra    = child_r[AW-1:0];
                    n_state = S_PICK;
                end else if (r_rdata > r_val) begin
                    b_we    = 1'b1;
                    b_wd    = r_rdata;
                    n_root  = child_l[AW-1:0];
                    n_state = S_LEFT;
                end else begin
                    b_we      = 1'b1;
                    sift_done = 1'b1;
                end
            end
            S_PICK: begin
                b_we = 1'b1;
                if (big_move) begin
                    b_wd    = big_v;
                    n_root  = big_i;
                    n_state = S_LEFT;
                end else begin
                    sift_done = 1'b1;
                end
            end
            W_STEP: begin
                if (r_k == 3'd4) begin
                    n_ridx  = '0;
                    n_state = B_EMIT;
                end else if (walk_below && (r_pos < r_n)) begin
                    b_re    = 1'b1;
                    b_ra    = '0;
                    n_state = E_TOP;
                end else begin
                    rec_en = 1'b1;
                    n_k    = r_k + 1'b1;
                end
            end
            E_TOP: begin
                n_sum   = r_sum + SW'(r_rdata);
                n_pos   = r_pos + 1'b1;
                n_lastv = r_rdata;
                if (r_size == CW'(1)) begin
                    n_size  = '0;
                    n_state = W_STEP;
                end else begin
                    b_re    = 1'b1;
                    b_ra    = AW'(r_size - 1'b1);
                    n_state = E_LAST;
                end
            end
            E_LAST: begin
                n_val   = r_rdata;
                n_size  = r_size - 1'b1;
                n_root  = '0;
                n_build = 1'b0;
                n_state = S_LEFT;
            end
            B_EMIT: begin
                if (r_empty) begin
                    ld_kind = KIND_NONE;
                end else if (r_ridx == 3'd4) begin
                    ld_kind = KIND_TOTAL;
                    ld_val  = r_t;
                    ld_rank = RANK_W'(r_n);
                end else begin
                    ld_kind = t_kind'(r_ridx);
                    ld_val  = VAL_W'(r_lv[~r_ridx[1:0]]);
                    ld_rank = RANK_W'(r_rk[~r_ridx[1:0]]);
                    ld_fin  = 1'b0;
                end
                if (out_free) begin
                    out_load = 1'b1;
                    n_ridx   = r_ridx + 1'b1;
                    if (ld_fin) begin
                        n_state = B_IDLE;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase

        // after a sift, continue the heap build or return to the walk
        if (sift_done) begin
            if (r_build && (r_i != AW'(1))) begin
                n_i     = r_i - 1'b1;
                n_state = B_HRD;
            end else begin
                n_state = W_STEP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_t     <= n_t;
        r_drop  <= n_drop;
        r_empty <= n_empty;
        r_t49   <= n_t49;
        r_i     <= n_i;
        r_root  <= n_root;
        r_size  <= n_size;
        r_val   <= n_val;
        r_lval  <= n_lval;
        r_build <= n_build;
        r_sum   <= n_sum;
        r_pos   <= n_pos;
        r_lastv <= n_lastv;
        r_k     <= n_k;
        r_ridx  <= n_ridx;
        if (job_start) begin
            r_thr[0] <= {2'b00, i_job[VAL_W:3]};
            r_thr[1] <= {1'b0, i_job[VAL_W:2]};
        end
        if (thr_load) begin
            r_thr[2] <= t3[VAL_W+1:2];
        end
        if (rec_en) begin
            r_rk[r_k[1:0]] <= r_pos;
            r_lv[r_k[1:0]] <= r_lastv;
        end
    end

    // job_start sets N25 and N50 directly from the raw job total rather than from r_t
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_okind <= ld_kind;
            r_oval  <= ld_val;
            r_orank <= ld_rank;
            r_oovf  <= r_drop;
            r_ofin  <= ld_fin;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_stat_kind    = r_okind;
    assign o_length_value = r_oval;
    assign o_rank         = r_orank;
    assign o_overflow     = r_oovf;
    assign o_final_res    = r_ofin;

    a_final_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_final_res |-> (o_stat_kind == KIND_TOTAL || o_stat_kind == KIND_NONE))
        else $error("final result is not a total or none result");

    a_sift_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEFT) |-> (CW'(r_root) < r_size))
        else $error("sift root outside heap");

    a_walk_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == W_STEP || r_state == E_TOP) |-> (r_pos <= r_n))
        else $error("walk rank beyond item count");

    a_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_we |-> !i_wr_en)
        else $error("load write collides with sort write");

endmodule

[tb/length_nxx_statistics_tb.sv]
// Testbench for length_nxx_statistics: directed and random sets of lengths, checked
// against an in-bench N-statistics predictor. Depends on lns_pkg and the block RTL.
module length_nxx_statistics_tb;
    import lns_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000000;

    typedef struct {
        t_kind              kind;
        logic [VAL_W-1:0]   value;
        logic [RANK_W-1:0]  rank;
        logic               ovf;
        logic               fin;
    } stat_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [LEN_W-1:0]  i_length = '0;
    logic              i_has_length = 1'b0;
    logic              i_last = 1'b0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [KIND_W-1:0] o_stat_kind;
    logic [VAL_W-1:0]  o_length_value;
    logic [RANK_W-1:0] o_rank;
    logic              o_overflow;
    logic              o_final_res;

    length_nxx_statistics uut (.*);

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [LEN_W-1:0] set_lengths[$];
    logic [VAL_W-1:0] set_total = '0;
    logic             set_dropped = 1'b0;
    stat_t            expected_stats[$];

    int  mismatches = 0;
    int  results_seen = 0;
    int  sets_sent = 0;
    int  items_sent = 0;
    bit  tx_idle_en = 1'b1;
    bit  rx_idle_en = 1'b1;
    int  rx_hold = 0;
    int  rx_gap = 0;
    int  quiet_cycles = 0;

    function automatic void push_stat(t_kind k, logic [VAL_W-1:0] v, logic [RANK_W-1:0] r,
                                      logic f);
        stat_t s;
        s.kind = k; s.value = v; s.rank = r; s.ovf = set_dropped; s.fin = f;
        expected_stats = {expected_stats, s};
    endfunction

    // Sort descending, walk running sums to each threshold, queue five results (one none result for an empty set).
    function automatic void predict_report();
        logic [LEN_W-1:0] srt[$];
        longint unsigned  thr[4];
        longint unsigned  sum;
        int               pos;
        logic [VAL_W-1:0] lv[4];
        logic [RANK_W-1:0] rk[4];
        t_kind            kinds[4];
        if (set_lengths.size() == 0) begin
            push_stat(KIND_NONE, '0, '0, 1'b1);
            return;
        end
        srt = set_lengths;
        srt.rsort();
        thr[0] = set_total / 4;
        thr[1] = set_total / 2;
        thr[2] = (3 * longint'(set_total)) / 4;
        thr[3] = (98 * longint'(set_total)) / 100;
        sum = 0;
        pos = 0;
        for (int k = 0; k < 4; k++) begin
            while (sum < thr[k] && pos < srt.size()) begin
                sum += srt[pos];
                pos++;
            end
            rk[k] = RANK_W'(pos);
            lv[k] = (pos != 0) ? VAL_W'(srt[pos-1]) : '0;
        end
        kinds = '{KIND_N25, KIND_N50, KIND_N75, KIND_N98};
        for (int k = 3; k >= 0; k--)
            push_stat(kinds[k], lv[k], rk[k], 1'b0);
        push_stat(KIND_TOTAL, set_total, RANK_W'(set_lengths.size()), 1'b1);
    endfunction

    function automatic void predict_item(logic [LEN_W-1:0] len, logic has, logic lst);
        if (has) begin
            if (set_lengths.size() < MAX_ITEMS_DEF) begin
                set_lengths = {set_lengths, len};
                set_total = set_total + len;
            end else begin
                set_dropped = 1'b1;
            end
        end
        if (lst) begin
            predict_report();
            set_lengths.delete();
            set_total = '0;
            set_dropped = 1'b0;
            sets_sent++;
        end
    endfunction

    task automatic send_length(logic [LEN_W-1:0] len, logic has, logic lst);
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_length <= len;
        i_has_length <= has;
        i_last <= lst;
        do @(posedge i_clk); while (!o_ready);
        predict_item(len, has, lst);
        items_sent++;
    endtask

    function automatic logic [LEN_W-1:0] rand_length();
        case ($urandom_range(0, 4))
            0: return LEN_W'($urandom());
            1: return LEN_W'($urandom_range(0, 15));
            2: return LEN_W'({$urandom_range(0, 1), 30'h3FFFFFFF} >> $urandom_range(0, 30));
            default: return LEN_W'($urandom_range(0, 100000));
        endcase
    endfunction

    task automatic send_set(int n);
        for (int i = 0; i < n; i++)
            send_length(rand_length(), 1'b1, i == n - 1);
    endtask

    task automatic wait_drained();
        while (expected_stats.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_length('0, 1'b0, 1'b1);                    // empty set
        send_length({LEN_W{1'b1}}, 1'b1, 1'b1);         // single maximum length
        send_length('0, 1'b1, 1'b1);                    // zero total
        send_length('0, 1'b1, 1'b0);
        send_length('0, 1'b1, 1'b1);
        send_length(31'd1, 1'b1, 1'b1);                 // thresholds all below one
        send_length({LEN_W{1'b1}}, 1'b1, 1'b0);
        send_length('0, 1'b1, 1'b0);
        send_length(31'd1, 1'b1, 1'b1);
        send_length(31'd7, 1'b1, 1'b0);                 // end marker with no length
        send_length(31'd5, 1'b0, 1'b0);
        send_length(31'd3, 1'b0, 1'b1);
        for (int i = 0; i < 6; i++)
            send_length({LEN_W{1'b1}}, 1'b1, i == 5);   // equal maximum lengths
        for (int i = 0; i < 5; i++)
            send_length(LEN_W'(31'h55555555 >> i), 1'b1, i == 4);
    endtask

    // Stall the receiver long enough for results to back up into the input.
    task automatic test_backpressure();
        rx_hold = 600;
        for (int s = 0; s < 6; s++) send_set($urandom_range(1, 4));
    endtask

    task automatic test_random(int target);
        int start;
        start = items_sent;
        while (items_sent - start < target) begin
            case ($urandom_range(0, 9))
                0: send_length(rand_length(), 1'b0, 1'b1);
                1: send_length(rand_length(), 1'b0, 1'b0);
                2: send_set($urandom_range(20, 60));
                default: send_set($urandom_range(1, 12));
            endcase
        end
    endtask

    // receiver: long hold when asked, else random stall bursts
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            i_ready <= 1'b0;
            rx_hold--;
        end else if (rx_gap > 0) begin
            i_ready <= 1'b0;
            rx_gap--;
        end else begin
            i_ready <= 1'b1;
            if (rx_idle_en && $urandom_range(0, 5) == 0) rx_gap = $urandom_range(1, 8);
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        stat_t e;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (expected_stats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d value %0d rank %0d",
                             o_stat_kind, o_length_value, o_rank);
            end else begin
                e = expected_stats.pop_front();
                if (o_stat_kind !== e.kind || o_length_value !== e.value ||
                    o_rank !== e.rank || o_overflow !== e.ovf || o_final_res !== e.fin) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp kind %0d val %0d rank %0d ovf %0b fin %0b, got kind %0d val %0d rank %0d ovf %0b fin %0b",
                                 e.kind, e.value, e.rank, e.ovf, e.fin, o_stat_kind,
                                 o_length_value, o_rank, o_overflow, o_final_res);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(230);
        // final stretch without idling
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random(50);
        i_valid <= 1'b0;
        wait_drained();
        repeat (300) @(posedge i_clk);
        $display("Covered %0d sets from %0d length transactions, %0d results checked.",
                 sets_sent, items_sent, results_seen);
        if (mismatches == 0 && expected_stats.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_stats.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
